// File: hdl/icl_pkg.sv
// Shared constants, codes and controller/datapath types for the inode cache table.
`timescale 1ns / 1ps
`default_nettype none
package icl_pkg;
   localparam int ENTRIES = 32;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int MAX_USE = 255;
   localparam int USE_W   = $clog2(MAX_USE + 1);
   localparam int REFS_W  = 16;
   localparam int DEV_W   = 16;
   localparam int INO_W   = 32;

   typedef enum logic [2:0] {
      OP_GET     = 3'd0,
      OP_RELEASE = 3'd1,
      OP_DIRTY   = 3'd2,
      OP_QUERY   = 3'd3,
      OP_SYNC    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_LOADED   = 3'd1,
      ST_LOADFAIL = 3'd2,
      ST_FULL     = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   typedef struct packed {
      logic load;
      logic scan_en;
      logic finish_en;
   } cmd_type;

   typedef struct packed {
      logic start_scan;
      logic scan_last;
      logic hit_now;
      logic sync_hold;
      logic out_free;
   } stat_type;
endpackage
`default_nettype wire

// File: hdl/icl_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface icl_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [15:0] device;
   logic [31:0] inode_number;
   logic [4:0]  slot;
   logic [5:0]  root_slot;
   logic        read_ok;
   modport source (output valid, operation, device, inode_number, slot, root_slot, read_ok,
                   input ready);
   modport sink (input valid, operation, device, inode_number, slot, root_slot, read_ok,
                 output ready);
endinterface

interface icl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [4:0]  entry_index;
   logic        write_back;
   logic [15:0] write_back_device;
   logic [31:0] write_back_inode;
   logic        in_use;
   logic        last;
   modport source (output valid, status, entry_index, write_back, write_back_device,
                   write_back_inode, in_use, last, input ready);
   modport sink (input valid, status, entry_index, write_back, write_back_device,
                 write_back_inode, in_use, last, output ready);
endinterface
`default_nettype wire

// File: hdl/icl_ctrl.sv
// Controller state machine: accept, scan, finish.
`timescale 1ns / 1ps
`default_nettype none
module icl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire icl_pkg::stat_type stat,
   output icl_pkg::cmd_type       cmd
);
   import icl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.start_scan ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.scan_en = !(stat.sync_hold && !stat.out_free);
            if (cmd.scan_en && (stat.hit_now || stat.scan_last)) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish_en = stat.out_free;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// File: hdl/icl_datapath.sv
// Entry table, scan pointer, victim tracking and response register.
`timescale 1ns / 1ps
`default_nettype none
module icl_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   icl_req_if.sink               req_chan,
   icl_rsp_if.source             rsp_chan,
   input  wire icl_pkg::cmd_type cmd,
   output icl_pkg::stat_type     stat
);
   import icl_pkg::*;

   logic [DEV_W-1:0]  dev_mem_ff [ENTRIES], dev_mem_in [ENTRIES];
   logic [INO_W-1:0]  ino_mem_ff [ENTRIES], ino_mem_in [ENTRIES];
   logic [REFS_W-1:0] ref_mem_ff [ENTRIES], ref_mem_in [ENTRIES];
   logic [USE_W-1:0]  use_mem_ff [ENTRIES], use_mem_in [ENTRIES];
   logic [ENTRIES-1:0] dirty_ff, dirty_in;

   logic [2:0]       op_ff, op_in;
   logic [DEV_W-1:0] dev_ff, dev_in;
   logic [INO_W-1:0] ino_ff, ino_in;
   logic [4:0]       slot_ff, slot_in;
   logic [5:0]       root_ff, root_in;
   logic             ok_ff, ok_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             vic_v_ff, vic_v_in;
   logic [IDX_W-1:0] vic_idx_ff, vic_idx_in;
   logic [USE_W-1:0] vic_use_ff, vic_use_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             found_ff, found_in;
   logic             pend_v_ff, pend_v_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [DEV_W-1:0] pend_dev_ff, pend_dev_in;
   logic [INO_W-1:0] pend_ino_ff, pend_ino_in;

   logic             out_v_ff, out_v_in;
   logic [2:0]       out_st_ff, out_st_in;
   logic [4:0]       out_idx_ff, out_idx_in;
   logic             out_wb_ff, out_wb_in;
   logic [DEV_W-1:0] out_wdev_ff, out_wdev_in;
   logic [INO_W-1:0] out_wino_ff, out_wino_in;
   logic             out_use_ff, out_use_in;
   logic             out_last_ff, out_last_in;

   logic [IDX_W-1:0]  fin_idx, rd_idx;
   logic [DEV_W-1:0]  e_dev;
   logic [INO_W-1:0]  e_ino;
   logic [REFS_W-1:0] e_ref;
   logic [USE_W-1:0]  e_use;
   logic              e_dirty, slot_ok, m_get, m_cand, m_sync, m_query, out_free;

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign slot_ok  = 32'(slot_ff) < 32'(ENTRIES);

   always_comb begin
      if (op_ff == OP_GET) fin_idx = hit_ff ? hit_idx_ff : vic_idx_ff;
      else                 fin_idx = IDX_W'(slot_ff);
   end
   assign rd_idx  = cmd.finish_en ? fin_idx : idx_ff;
   assign e_dev   = dev_mem_ff[rd_idx];
   assign e_ino   = ino_mem_ff[rd_idx];
   assign e_ref   = ref_mem_ff[rd_idx];
   assign e_use   = use_mem_ff[rd_idx];
   assign e_dirty = dirty_ff[rd_idx];

   assign m_get   = (e_dev == dev_ff) && (e_ino == ino_ff);
   assign m_cand  = (e_ref == '0) && (!vic_v_ff || (vic_use_ff > e_use));
   assign m_sync  = ((e_dev == dev_ff) || (dev_ff == '0)) && e_dirty;
   assign m_query = (6'(idx_ff) != root_ff) && (e_dev == dev_ff) && (e_ref != '0);

   always_comb begin
      stat.start_scan = ((req_chan.operation == OP_GET) && (req_chan.device != '0))
                        || (req_chan.operation == OP_QUERY)
                        || (req_chan.operation == OP_SYNC);
      stat.scan_last  = idx_ff == IDX_W'(ENTRIES - 1);
      stat.hit_now    = (op_ff == OP_GET) && m_get;
      stat.sync_hold  = (op_ff == OP_SYNC) && m_sync && pend_v_ff;
      stat.out_free   = out_free;
   end

   always_comb begin
      dev_mem_in = dev_mem_ff;
      ino_mem_in = ino_mem_ff;
      ref_mem_in = ref_mem_ff;
      use_mem_in = use_mem_ff;
      dirty_in   = dirty_ff;
      op_in = op_ff; dev_in = dev_ff; ino_in = ino_ff;
      slot_in = slot_ff; root_in = root_ff; ok_in = ok_ff;
      idx_in = idx_ff;
      vic_v_in = vic_v_ff; vic_idx_in = vic_idx_ff; vic_use_in = vic_use_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff; found_in = found_ff;
      pend_v_in = pend_v_ff; pend_idx_in = pend_idx_ff;
      pend_dev_in = pend_dev_ff; pend_ino_in = pend_ino_ff;
      out_v_in = out_v_ff; out_st_in = out_st_ff; out_idx_in = out_idx_ff;
      out_wb_in = out_wb_ff; out_wdev_in = out_wdev_ff; out_wino_in = out_wino_ff;
      out_use_in = out_use_ff; out_last_in = out_last_ff;

      if (out_v_ff && rsp_chan.ready) out_v_in = 1'b0;

      if (cmd.load) begin
         op_in   = req_chan.operation;
         dev_in  = req_chan.device;
         ino_in  = req_chan.inode_number;
         slot_in = req_chan.slot;
         root_in = req_chan.root_slot;
         ok_in   = req_chan.read_ok;
         idx_in  = '0;
         vic_v_in = 1'b0; hit_in = 1'b0; found_in = 1'b0; pend_v_in = 1'b0;
      end

      if (cmd.scan_en) begin
         case (op_ff)
            OP_GET: begin
               if (m_get) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff;
               end else if (m_cand) begin
                  vic_v_in   = 1'b1;
                  vic_idx_in = idx_ff;
                  vic_use_in = e_use;
               end
            end
            OP_QUERY: if (m_query) found_in = 1'b1;
            OP_SYNC: begin
               if (m_sync) begin
                  dirty_in[idx_ff] = 1'b0;
                  if (pend_v_ff) begin
                     out_v_in = 1'b1; out_st_in = ST_DONE; out_idx_in = 5'(pend_idx_ff);
                     out_wb_in = 1'b1; out_wdev_in = pend_dev_ff; out_wino_in = pend_ino_ff;
                     out_use_in = 1'b0; out_last_in = 1'b0;
                  end
                  pend_v_in   = 1'b1;
                  pend_idx_in = idx_ff;
                  pend_dev_in = e_dev;
                  pend_ino_in = e_ino;
               end
            end
            default: ;
         endcase
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.finish_en) begin
         out_v_in = 1'b1; out_st_in = ST_DONE; out_idx_in = '0;
         out_wb_in = 1'b0; out_wdev_in = '0; out_wino_in = '0;
         out_use_in = 1'b0; out_last_in = 1'b1;
         case (op_ff)
            OP_GET: begin
               if (dev_ff == '0) begin
                  out_st_in = ST_LOADFAIL;
               end else if (hit_ff) begin
                  out_st_in  = ST_HIT;
                  out_idx_in = 5'(fin_idx);
                  if (32'(e_use) < 32'(MAX_USE)) use_mem_in[fin_idx] = e_use + 1'b1;
                  if (e_ref != '1) ref_mem_in[fin_idx] = e_ref + 1'b1;
               end else if (!vic_v_ff) begin
                  out_st_in = ST_FULL;
               end else begin
                  out_idx_in = 5'(fin_idx);
                  if (e_dirty) begin
                     out_wb_in   = 1'b1;
                     out_wdev_in = e_dev;
                     out_wino_in = e_ino;
                  end
                  dirty_in[fin_idx]   = 1'b0;
                  use_mem_in[fin_idx] = '0;
                  if (ok_ff) begin
                     out_st_in = ST_LOADED;
                     dev_mem_in[fin_idx] = dev_ff;
                     ino_mem_in[fin_idx] = ino_ff;
                     ref_mem_in[fin_idx] = REFS_W'(1);
                  end else begin
                     out_st_in = ST_LOADFAIL;
                     dev_mem_in[fin_idx] = '0;
                     ino_mem_in[fin_idx] = '0;
                     ref_mem_in[fin_idx] = '0;
                  end
               end
            end
            OP_RELEASE: begin
               out_idx_in = slot_ff;
               if (slot_ok && (e_ref != '0)) ref_mem_in[fin_idx] = e_ref - 1'b1;
            end
            OP_DIRTY: begin
               out_idx_in = slot_ff;
               if (slot_ok && (e_dev != '0)) dirty_in[fin_idx] = 1'b1;
            end
            OP_QUERY: out_use_in = found_ff;
            OP_SYNC: begin
               if (pend_v_ff) begin
                  out_idx_in  = 5'(pend_idx_ff);
                  out_wb_in   = 1'b1;
                  out_wdev_in = pend_dev_ff;
                  out_wino_in = pend_ino_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            dev_mem_ff[i] <= '0;
            ino_mem_ff[i] <= '0;
            ref_mem_ff[i] <= '0;
            use_mem_ff[i] <= '0;
         end
         dirty_ff  <= '0;
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         vic_v_ff  <= 1'b0;
         hit_ff    <= 1'b0;
         found_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         dev_mem_ff <= dev_mem_in;
         ino_mem_ff <= ino_mem_in;
         ref_mem_ff <= ref_mem_in;
         use_mem_ff <= use_mem_in;
         dirty_ff   <= dirty_in;
         out_v_ff   <= out_v_in;
         pend_v_ff  <= pend_v_in;
         vic_v_ff   <= vic_v_in;
         hit_ff     <= hit_in;
         found_ff   <= found_in;
         idx_ff     <= idx_in;
      end
      op_ff <= op_in; dev_ff <= dev_in; ino_ff <= ino_in;
      slot_ff <= slot_in; root_ff <= root_in; ok_ff <= ok_in;
      vic_idx_ff <= vic_idx_in; vic_use_ff <= vic_use_in; hit_idx_ff <= hit_idx_in;
      pend_idx_ff <= pend_idx_in; pend_dev_ff <= pend_dev_in; pend_ino_ff <= pend_ino_in;
      out_st_ff <= out_st_in; out_idx_ff <= out_idx_in; out_wb_ff <= out_wb_in;
      out_wdev_ff <= out_wdev_in; out_wino_ff <= out_wino_in;
      out_use_ff <= out_use_in; out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid             = out_v_ff;
   assign rsp_chan.status            = out_st_ff;
   assign rsp_chan.entry_index       = out_idx_ff;
   assign rsp_chan.write_back        = out_wb_ff;
   assign rsp_chan.write_back_device = out_wdev_ff;
   assign rsp_chan.write_back_inode  = out_wino_ff;
   assign rsp_chan.in_use            = out_use_ff;
   assign rsp_chan.last              = out_last_ff;
endmodule
`default_nettype wire

// File: hdl/inode_cache_lfu_table.sv
// Top level of the inode cache table with least-frequently-used replacement.
// One item at a time. Release, mark dirty, refused gets and unknown codes go
// straight to the finish state; get, query and sync walk the 32 entries one per
// cycle through the single table read port, unless a sync stalls (a get stops
// early on a hit). A sync gives one item per dirty match and stalls the
// walk while the response register is still held. The table clears at reset.
`timescale 1ns / 1ps
`default_nettype none
module inode_cache_lfu_table (
   input  wire logic clock,
   input  wire logic reset,
   icl_req_if.sink   req_chan,
   icl_rsp_if.source rsp_chan
);
   import icl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   icl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   icl_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while busy");

   a_partial_is_wb: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last) |->
         (rsp_chan.status == ST_DONE && rsp_chan.write_back))
      else $error("non-final item is not a sync write-back");

   a_wb_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.write_back) |->
         (rsp_chan.write_back_device == '0 && rsp_chan.write_back_inode == '0))
      else $error("write-back key without write-back");
endmodule
`default_nettype wire

// File: tb/icl_tb_pkg.sv
// Reserved for testbench-side shared items; the block package supplies all codes.
`timescale 1ns / 1ps
package icl_tb_pkg;
   import icl_pkg::*;
   localparam int WATCHDOG_CYCLES = 20000;
endpackage

// File: tb/tb_top.sv
// Testbench for the inode cache table: self-checking predictor, directed and random items.
`timescale 1ns / 1ps
module tb_top;
   import icl_pkg::*;
   import icl_tb_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  entry_index;
      logic        write_back;
      logic [15:0] wb_device;
      logic [31:0] wb_inode;
      logic        in_use;
      logic        last;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   always #6 clock = ~clock;

   icl_req_if req_chan();
   icl_rsp_if rsp_chan();

   inode_cache_lfu_table dut (.clock(clock), .reset(reset), .req_chan(req_chan),
                              .rsp_chan(rsp_chan));

   logic [15:0] tbl_dev   [ENTRIES];
   logic [31:0] tbl_ino   [ENTRIES];
   logic [15:0] tbl_refs  [ENTRIES];
   logic [7:0]  tbl_uses  [ENTRIES];
   logic        tbl_dirty [ENTRIES];

   answer_type pending_answers[$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int errors = 0, n_items = 0, n_answers = 0, n_writebacks = 0, idle_cycles = 0;
   logic [15:0] dev_pool [4] = '{16'h0001, 16'h0002, 16'hFFFF, 16'h8000};

   function automatic answer_type mk(logic [2:0] st, logic [4:0] idx, logic wb,
                                     logic [15:0] wd, logic [31:0] wi, logic iu,
                                     logic lst);
      answer_type a;
      a = '{st, idx, wb, wd, wi, iu, lst};
      return a;
   endfunction

   task automatic predict_cache(logic [2:0] op, logic [15:0] dev, logic [31:0] ino,
                                logic [4:0] slot, logic [5:0] root, logic ok);
      int victim;
      int cnt;
      logic found;
      answer_type a;
      victim = -1;
      cnt = 0;
      found = 0;
      case (op)
         OP_GET: begin
            if (dev == 0) begin
               pending_answers.push_back(mk(ST_LOADFAIL, 0, 0, 0, 0, 0, 1));
               return;
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_dev[i] == dev && tbl_ino[i] == ino) begin
                  if (tbl_uses[i] < MAX_USE) tbl_uses[i]++;
                  if (tbl_refs[i] != 16'hFFFF) tbl_refs[i]++;
                  pending_answers.push_back(mk(ST_HIT, 5'(i), 0, 0, 0, 0, 1));
                  return;
               end
               if (tbl_refs[i] == 0 && (victim < 0 || tbl_uses[victim] > tbl_uses[i]))
                  victim = i;
            end
            if (victim < 0) begin
               pending_answers.push_back(mk(ST_FULL, 0, 0, 0, 0, 0, 1));
               return;
            end
            a = mk(ok ? ST_LOADED : ST_LOADFAIL, 5'(victim), 0, 0, 0, 0, 1);
            if (tbl_dirty[victim]) begin
               a.write_back = 1;
               a.wb_device  = tbl_dev[victim];
               a.wb_inode   = tbl_ino[victim];
               tbl_dirty[victim] = 0;
            end
            tbl_uses[victim] = 0;
            tbl_dev[victim]  = ok ? dev : '0;
            tbl_ino[victim]  = ok ? ino : '0;
            tbl_refs[victim] = ok ? 16'd1 : 16'd0;
            pending_answers.push_back(a);
         end
         OP_RELEASE: begin
            if (tbl_refs[slot] > 0) tbl_refs[slot]--;
            pending_answers.push_back(mk(ST_DONE, slot, 0, 0, 0, 0, 1));
         end
         OP_DIRTY: begin
            if (tbl_dev[slot] != 0) tbl_dirty[slot] = 1;
            pending_answers.push_back(mk(ST_DONE, slot, 0, 0, 0, 0, 1));
         end
         OP_QUERY: begin
            for (int i = 0; i < ENTRIES; i++)
               if (i != root && tbl_dev[i] == dev && tbl_refs[i] > 0) found = 1;
            pending_answers.push_back(mk(ST_DONE, 0, 0, 0, 0, found, 1));
         end
         OP_SYNC: begin
            for (int i = 0; i < ENTRIES; i++)
               if ((tbl_dev[i] == dev || dev == 0) && tbl_dirty[i]) begin
                  pending_answers.push_back(mk(ST_DONE, 5'(i), 1, tbl_dev[i], tbl_ino[i],
                                               0, 0));
                  tbl_dirty[i] = 0;
                  cnt++;
               end
            if (cnt == 0) pending_answers.push_back(mk(ST_DONE, 0, 0, 0, 0, 0, 1));
            else pending_answers[$].last = 1;
         end
         default: pending_answers.push_back(mk(ST_DONE, 0, 0, 0, 0, 0, 1));
      endcase
   endtask

   task automatic send_item(logic [2:0] op, logic [15:0] dev, logic [31:0] ino,
                            logic [4:0] slot, logic [5:0] root, logic ok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid        <= 1;
      req_chan.operation    <= op;
      req_chan.device       <= dev;
      req_chan.inode_number <= ino;
      req_chan.slot         <= slot;
      req_chan.root_slot    <= root;
      req_chan.read_ok      <= ok;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_cache(op, dev, ino, slot, root, ok);
      n_items++;
   endtask

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      answer_type got, exp_a;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status, rsp_chan.entry_index, rsp_chan.write_back,
                 rsp_chan.write_back_device, rsp_chan.write_back_inode,
                 rsp_chan.in_use, rsp_chan.last};
         n_answers++;
         if (got.write_back) n_writebacks++;
         if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected item %h", $time, got);
         end else begin
            exp_a = pending_answers.pop_front();
            if (got !== exp_a) begin
               errors++;
               $display("%0t: mismatch expected st=%0d idx=%0d wb=%0b dev=%h ino=%h iu=%0b last=%0b",
                        $time, exp_a.status, exp_a.entry_index, exp_a.write_back,
                        exp_a.wb_device, exp_a.wb_inode, exp_a.in_use, exp_a.last);
               $display("%0t:          actual   st=%0d idx=%0d wb=%0b dev=%h ino=%h iu=%0b last=%0b",
                        $time, got.status, got.entry_index, got.write_back,
                        got.wb_device, got.wb_inode, got.in_use, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(OP_GET, 16'h0000, 32'h1, 0, 32, 1);
      send_item(OP_GET, 16'hFFFF, 32'hFFFFFFFF, 0, 32, 1);
      send_item(OP_GET, 16'hFFFF, 32'hFFFFFFFF, 0, 32, 1);
      send_item(OP_GET, 16'h0001, 32'h0, 0, 32, 1);
      send_item(OP_DIRTY, 0, 0, 5'd0, 32, 0);
      send_item(OP_DIRTY, 0, 0, 5'd31, 32, 0);
      send_item(OP_QUERY, 16'hFFFF, 0, 0, 6'd0, 0);
      send_item(OP_QUERY, 16'hFFFF, 0, 0, 6'd32, 0);
      send_item(OP_QUERY, 16'hFFFF, 0, 0, 6'd63, 0);
      send_item(OP_SYNC, 16'h0002, 0, 0, 32, 0);
      send_item(OP_SYNC, 16'h0000, 0, 0, 32, 0);
      send_item(OP_SYNC, 16'h0000, 0, 0, 32, 0);
      send_item(OP_RELEASE, 0, 0, 5'd0, 32, 0);
      send_item(OP_RELEASE, 0, 0, 5'd0, 32, 0);
      send_item(OP_RELEASE, 0, 0, 5'd0, 32, 0);
      send_item(OP_DIRTY, 0, 0, 5'd1, 32, 0);
      send_item(OP_GET, 16'h0002, 32'h5, 0, 32, 0);
      send_item(3'd5, 16'hFFFF, 32'hFFFFFFFF, 5'd31, 6'd63, 1);
      send_item(3'd7, 0, 0, 0, 0, 0);
   endtask

   // fill the table with held references so the full case is reached
   task automatic test_table_full();
      for (int i = 0; i < ENTRIES + 1; i++) send_item(OP_GET, 16'h0003, i + 100, 0, 32, 1);
      send_item(OP_QUERY, 16'h0003, 0, 0, 6'd4, 0);
      for (int i = 0; i < ENTRIES; i++) send_item(OP_DIRTY, 0, 0, 5'(i), 32, 0);
      send_item(OP_SYNC, 16'h0003, 0, 0, 32, 0);
      for (int i = 0; i < ENTRIES; i++) send_item(OP_RELEASE, 0, 0, 5'(i), 32, 0);
   endtask

   task automatic test_random(int count);
      logic [2:0] op;
      logic [15:0] dev;
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         op = r < 40 ? OP_GET : r < 58 ? OP_RELEASE : r < 75 ? OP_DIRTY :
              r < 87 ? OP_QUERY : r < 97 ? OP_SYNC : 3'($urandom_range(7, 5));
         dev = $urandom_range(9) == 0 ? 16'($urandom) : dev_pool[$urandom_range(3)];
         if (op == OP_SYNC && $urandom_range(3) == 0) dev = 0;
         send_item(op, dev, $urandom_range(9) == 0 ? $urandom : $urandom_range(12),
                   5'($urandom_range(31)), $urandom_range(4) == 0 ? 6'($urandom) : 6'd32,
                   $urandom_range(7) != 0);
      end
   endtask

   // repeated hits on one key raise its use counter
   task automatic test_repeat_hits(int count);
      for (int i = 0; i < count; i++) send_item(OP_GET, 16'h0001, 32'h7, 0, 32, 1);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_dev[i] = 0; tbl_ino[i] = 0; tbl_refs[i] = 0; tbl_uses[i] = 0; tbl_dirty[i] = 0;
      end
      req_chan.valid <= 0;
      req_chan.operation <= 0;
      req_chan.device <= 0;
      req_chan.inode_number <= 0;
      req_chan.slot <= 0;
      req_chan.root_slot <= 0;
      req_chan.read_ok <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 12; recv_idle_pct = 59;
      test_directed();
      test_table_full();
      test_random(30);
      send_idle_pct = 59; recv_idle_pct = 12;
      test_random(30);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(30);
      test_repeat_hits(30);
      drain();
      $display("Covered hits, loads, refused and full gets, releases, dirty marks, queries,");
      $display("syncs and unknown codes: %0d items, %0d results checked (%0d write-backs)",
               n_items, n_answers, n_writebacks);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// File: filelist.f
hdl/icl_pkg.sv
hdl/icl_if.sv
hdl/icl_ctrl.sv
hdl/icl_datapath.sv
hdl/inode_cache_lfu_table.sv
tb/icl_tb_pkg.sv
tb/tb_top.sv
